// File: hdl/dgc_pkg.sv
package dgc_pkg;

    // default pointer coordinate width
    localparam int COORD_BITS_DEF = 12;

    // input item kinds
    localparam logic [1:0] KIND_MOTION  = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLED       = 3'd0;
    localparam logic [2:0] REG_DWELL_TICKS   = 3'd1;
    localparam logic [2:0] REG_TOLERANCE     = 3'd2;
    localparam logic [2:0] REG_ACTION_LEFT   = 3'd3;
    localparam logic [2:0] REG_ACTION_RIGHT  = 3'd4;
    localparam logic [2:0] REG_ACTION_TOP    = 3'd5;
    localparam logic [2:0] REG_ACTION_BOTTOM = 3'd6;
    localparam logic [2:0] REG_FAST_GESTURE  = 3'd7;

    // gesture actions
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_CLICK  = 3'd1;
    localparam logic [2:0] ACT_DOUBLE = 3'd2;
    localparam logic [2:0] ACT_RIGHT  = 3'd3;
    localparam logic [2:0] ACT_MIDDLE = 3'd4;
    localparam logic [2:0] ACT_DRAG   = 3'd5;

    // mouse commands
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_L_RELEASE = 3'd1;
    localparam logic [2:0] CMD_LEFT_CLK  = 3'd2;
    localparam logic [2:0] CMD_DOUBLE    = 3'd3;
    localparam logic [2:0] CMD_RIGHT_CLK = 3'd4;
    localparam logic [2:0] CMD_MID_CLK   = 3'd5;
    localparam logic [2:0] CMD_L_PRESS   = 3'd6;

    // configuration register reset values
    localparam logic [7:0] DWELL_TICKS_RST = 8'd10;
    localparam logic [7:0] TOLERANCE_RST   = 8'd3;

    typedef struct packed {
        logic       enabled;
        logic [7:0] dwell_ticks;
        logic [7:0] tolerance;
        logic [2:0] action_left;
        logic [2:0] action_right;
        logic [2:0] action_top;
        logic [2:0] action_bottom;
        logic       fast_gesture;
    } t_cfg;

endpackage

// File: hdl/dgc_in_if.sv
interface dgc_in_if import dgc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic signed [11:0]    step_x;
    logic signed [11:0]    step_y;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;

    modport source (output valid, kind, step_x, step_y, pos_x, pos_y, input ready);
    modport sink (input valid, kind, step_x, step_y, pos_x, pos_y, output ready);
endinterface

// File: hdl/dgc_out_if.sv
interface dgc_out_if import dgc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            command;
    logic                  release_left;
    logic                  move_pointer;
    logic [COORD_BITS-1:0] move_x;
    logic [COORD_BITS-1:0] move_y;

    modport source (output valid, command, release_left, move_pointer, move_x, move_y,
                    input ready);
    modport sink (input valid, command, release_left, move_pointer, move_x, move_y,
                  output ready);
endinterface

// File: hdl/dgc_core.sv
module dgc_core import dgc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  t_cfg                  i_cfg,
    input  logic [1:0]            i_kind,
    input  logic signed [11:0]    i_step_x,
    input  logic signed [11:0]    i_step_y,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    output logic [2:0]            o_command,
    output logic                  o_release_left,
    output logic                  o_move_pointer,
    output logic [COORD_BITS-1:0] o_move_x,
    output logic [COORD_BITS-1:0] o_move_y
);

    localparam int GW = COORD_BITS + 1;
    localparam int GSQ = 2 * GW;

    typedef enum logic [1:0] {
        MODE_DWELL = 2'd0,
        MODE_DIR   = 2'd1,
        MODE_WAIT  = 2'd2
    } t_mode;

    t_mode                 r_mode, n_mode;
    logic [7:0]            r_elapsed, n_elapsed;
    logic [COORD_BITS-1:0] r_start_x, n_start_x;
    logic [COORD_BITS-1:0] r_start_y, n_start_y;
    logic                  r_left_held, n_left_held;

    logic signed [23:0]    sq_x, sq_y;
    logic [24:0]           step_sq;
    logic [15:0]           tol_sq;
    logic                  moving;
    logic                  expired;
    logic signed [GW-1:0]  gx, gy;
    logic [GW-1:0]         ax, ay;
    logic signed [GSQ-1:0] gsq_x, gsq_y;
    logic [GSQ:0]          gest_sq;
    logic                  far;
    logic [2:0]            act;

    // motion magnitude against the stillness radius
    assign sq_x    = i_step_x * i_step_x;
    assign sq_y    = i_step_y * i_step_y;
    assign step_sq = {1'b0, sq_x} + {1'b0, sq_y};
    assign tol_sq  = i_cfg.tolerance * i_cfg.tolerance;
    assign moving  = step_sq > {9'd0, tol_sq};
    assign expired = r_elapsed >= i_cfg.dwell_ticks;

    // gesture displacement from the recorded start
    assign gx      = $signed({1'b0, i_pos_x}) - $signed({1'b0, r_start_x});
    assign gy      = $signed({1'b0, i_pos_y}) - $signed({1'b0, r_start_y});
    assign ax      = gx[GW-1] ? GW'(-gx) : GW'(gx);
    assign ay      = gy[GW-1] ? GW'(-gy) : GW'(gy);
    assign gsq_x   = gx * gx;
    assign gsq_y   = gy * gy;
    assign gest_sq = {1'b0, gsq_x} + {1'b0, gsq_y};
    assign far     = gest_sq > (GSQ+1)'(tol_sq);

    // dominant direction, vertical wins a tie
    always_comb begin
        if (ax > ay) begin
            act = gx[GW-1] ? i_cfg.action_left : i_cfg.action_right;
        end else begin
            act = gy[GW-1] ? i_cfg.action_top : i_cfg.action_bottom;
        end
    end

    // next state and result of one request
    always_comb begin
        n_mode         = r_mode;
        n_elapsed      = r_elapsed;
        n_start_x      = r_start_x;
        n_start_y      = r_start_y;
        n_left_held    = r_left_held;
        o_command      = CMD_NONE;
        o_release_left = 1'b0;
        o_move_pointer = 1'b0;
        o_move_x       = '0;
        o_move_y       = '0;
        case (i_kind)
            KIND_TICK: begin
                if (r_elapsed != 8'hFF) begin
                    n_elapsed = r_elapsed + 8'd1;
                end
            end
            KIND_RESTART: begin
                n_mode    = MODE_DWELL;
                n_elapsed = 8'd0;
                if (r_left_held) begin
                    n_left_held    = 1'b0;
                    o_command      = CMD_L_RELEASE;
                    o_release_left = 1'b1;
                end
            end
            KIND_MOTION: begin
                if (i_cfg.enabled) begin
                    case (r_mode)
                        MODE_DIR: begin
                            if (moving) begin
                                if (!i_cfg.fast_gesture) begin
                                    n_elapsed = 8'd0;
                                end
                            end else if (expired) begin
                                n_mode = MODE_WAIT;
                                if (far) begin
                                    o_move_pointer = 1'b1;
                                    o_move_x       = r_start_x;
                                    o_move_y       = r_start_y;
                                    // a held button is released before the new action
                                    if (r_left_held) begin
                                        n_left_held    = 1'b0;
                                        o_release_left = 1'b1;
                                        o_command      = CMD_L_RELEASE;
                                    end
                                    if (!(r_left_held && act == ACT_DRAG)) begin
                                        case (act)
                                            ACT_CLICK:  o_command = CMD_LEFT_CLK;
                                            ACT_DOUBLE: o_command = CMD_DOUBLE;
                                            ACT_RIGHT:  o_command = CMD_RIGHT_CLK;
                                            ACT_MIDDLE: o_command = CMD_MID_CLK;
                                            ACT_DRAG: begin
                                                o_command   = CMD_L_PRESS;
                                                n_left_held = 1'b1;
                                            end
                                            default: ;
                                        endcase
                                    end
                                end
                            end
                        end
                        MODE_WAIT: begin
                            if (moving) begin
                                n_elapsed = 8'd0;
                                n_mode    = MODE_DWELL;
                            end
                        end
                        default: begin
                            if (moving) begin
                                n_elapsed = 8'd0;
                            end else if (expired) begin
                                n_elapsed = 8'd0;
                                n_start_x = i_pos_x;
                                n_start_y = i_pos_y;
                                n_mode    = MODE_DIR;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // gesture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DWELL;
            r_elapsed   <= 8'd0;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_left_held <= 1'b0;
        end else if (i_adv) begin
            r_mode      <= n_mode;
            r_elapsed   <= n_elapsed;
            r_start_x   <= n_start_x;
            r_start_y   <= n_start_y;
            r_left_held <= n_left_held;
        end
    end

endmodule

// File: hdl/dwell_gesture_click_fsm_unit.sv
// An accepted request is held in the input register, and its result in the result register.
// Throughput: one request per cycle unless stalled; the input and result registers
// form a two-stage pipe, and the gesture state updates as each request leaves stage one.
// Reset (i_rst_n, synchronous, active low) empties both stages, sets dwell mode,
// clears the countdown, start point and held button, and loads register defaults.
module dwell_gesture_click_fsm_unit import dgc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dgc_in_if.sink     i_req,
    dgc_out_if.source  o_res,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    t_cfg                  r_cfg;
    logic                  r_in_valid;
    logic [1:0]            r_kind;
    logic signed [11:0]    r_step_x, r_step_y;
    logic [COORD_BITS-1:0] r_pos_x, r_pos_y;
    logic                  r_out_valid;
    logic [2:0]            r_command;
    logic                  r_release_left;
    logic                  r_move_pointer;
    logic [COORD_BITS-1:0] r_move_x, r_move_y;

    logic                  adv;
    logic [2:0]            n_command;
    logic                  n_release_left;
    logic                  n_move_pointer;
    logic [COORD_BITS-1:0] n_move_x, n_move_y;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled       <= 1'b0;
            r_cfg.dwell_ticks   <= DWELL_TICKS_RST;
            r_cfg.tolerance     <= TOLERANCE_RST;
            r_cfg.action_left   <= ACT_CLICK;
            r_cfg.action_right  <= ACT_RIGHT;
            r_cfg.action_top    <= ACT_DOUBLE;
            r_cfg.action_bottom <= ACT_DRAG;
            r_cfg.fast_gesture  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLED:       r_cfg.enabled       <= i_cfg_data[0];
                REG_DWELL_TICKS:   r_cfg.dwell_ticks   <= i_cfg_data;
                REG_TOLERANCE:     r_cfg.tolerance     <= i_cfg_data;
                REG_ACTION_LEFT:   r_cfg.action_left   <= i_cfg_data[2:0];
                REG_ACTION_RIGHT:  r_cfg.action_right  <= i_cfg_data[2:0];
                REG_ACTION_TOP:    r_cfg.action_top    <= i_cfg_data[2:0];
                REG_ACTION_BOTTOM: r_cfg.action_bottom <= i_cfg_data[2:0];
                REG_FAST_GESTURE:  r_cfg.fast_gesture  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake: stage one moves on when the result register is free or draining
    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_kind   <= i_req.kind;
            r_step_x <= i_req.step_x;
            r_step_y <= i_req.step_y;
            r_pos_x  <= i_req.pos_x;
            r_pos_y  <= i_req.pos_y;
        end
    end

    dgc_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_cfg          (r_cfg),
        .i_kind         (r_kind),
        .i_step_x       (r_step_x),
        .i_step_y       (r_step_y),
        .i_pos_x        (r_pos_x),
        .i_pos_y        (r_pos_y),
        .o_command      (n_command),
        .o_release_left (n_release_left),
        .o_move_pointer (n_move_pointer),
        .o_move_x       (n_move_x),
        .o_move_y       (n_move_y)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_command      <= n_command;
            r_release_left <= n_release_left;
            r_move_pointer <= n_move_pointer;
            r_move_x       <= n_move_x;
            r_move_y       <= n_move_y;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.command      = r_command;
    assign o_res.release_left = r_release_left;
    assign o_res.move_pointer = r_move_pointer;
    assign o_res.move_x       = r_move_x;
    assign o_res.move_y       = r_move_y;

endmodule

// File: sim/tb_dwell_gesture_click_fsm_unit.sv
module tb_dwell_gesture_click_fsm_unit;
    import dgc_pkg::*;

    localparam int COORD_BITS     = COORD_BITS_DEF;
    localparam int CMAX           = (1 << COORD_BITS) - 1;
    localparam int CLK_PERIOD     = 4;
    localparam int DRAIN_CYCLES   = 6;
    localparam int LONG_HOLD      = 40;
    localparam int TIMEOUT_CYCLES = 200000;

    // codes the package leaves out
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [2:0] ACT_RSVD6   = 3'd6;
    localparam logic [2:0] ACT_RSVD7   = 3'd7;

    typedef enum logic [1:0] {
        GM_DWELL = 2'd0,
        GM_DIR   = 2'd1,
        GM_WAIT  = 2'd2
    } t_gmode;

    typedef struct packed {
        logic [1:0]            kind;
        logic signed [11:0]    step_x;
        logic signed [11:0]    step_y;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } t_req;

    typedef struct packed {
        logic [2:0]            command;
        logic                  release_left;
        logic                  move_pointer;
        logic [COORD_BITS-1:0] move_x;
        logic [COORD_BITS-1:0] move_y;
    } t_res;

    typedef enum logic {ROW_REQ, ROW_REG} t_row_op;

    typedef struct {
        t_row_op    op;
        t_req       req;
        bit         has_exp;
        t_res       exp;
        logic [2:0] reg_idx;
        logic [7:0] reg_val;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [2:0] cfg_idx;
    logic [7:0] cfg_data;

    dgc_in_if  #(.COORD_BITS(COORD_BITS)) req_bus ();
    dgc_out_if #(.COORD_BITS(COORD_BITS)) res_bus ();

    dwell_gesture_click_fsm_unit #(.COORD_BITS(COORD_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_res      (res_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // gesture state and register copy of the predictor
    t_cfg                  cfg_model;
    t_gmode                g_mode;
    logic [7:0]            g_elapsed;
    logic [COORD_BITS-1:0] g_start_x;
    logic [COORD_BITS-1:0] g_start_y;
    logic                  g_held;

    t_res pending_cmds[$];
    bit   offer_has_exp;
    t_res offer_exp;
    bit   tx_idle_on;
    bit   rx_idle_on;
    int   long_hold;
    int   n_errors;
    int   n_sent;
    int   n_checked;
    int   n_returns;
    int   n_settings;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout: %0d results still outstanding", pending_cmds.size());
        $display("FAILED: results differ");
        $finish;
    end

    // squared distance against squared tolerance
    function automatic bit beyond_radius(int dx, int dy);
        int tol;
        tol = int'(cfg_model.tolerance);
        return (dx * dx + dy * dy) > (tol * tol);
    endfunction

    // evaluate one gesture action, releasing a held button first
    function automatic t_res fire_action(logic [2:0] act);
        t_res o;
        o = '0;
        o.move_pointer = 1'b1;
        o.move_x = g_start_x;
        o.move_y = g_start_y;
        if (g_held) begin
            g_held = 1'b0;
            o.release_left = 1'b1;
            o.command = CMD_L_RELEASE;
            if (act == ACT_DRAG) return o;
        end
        case (act)
            ACT_CLICK:  o.command = CMD_LEFT_CLK;
            ACT_DOUBLE: o.command = CMD_DOUBLE;
            ACT_RIGHT:  o.command = CMD_RIGHT_CLK;
            ACT_MIDDLE: o.command = CMD_MID_CLK;
            ACT_DRAG: begin
                o.command = CMD_L_PRESS;
                g_held = 1'b1;
            end
            default: ;
        endcase
        return o;
    endfunction

    // next command for one request, advancing the gesture state
    function automatic t_res predict_click(t_req r);
        t_res       o;
        bit         moving;
        int         gx, gy, ax, ay;
        logic [2:0] act;
        o = '0;
        case (r.kind)
            KIND_TICK: begin
                if (g_elapsed != 8'hFF) g_elapsed = g_elapsed + 8'd1;
            end
            KIND_RESTART: begin
                g_mode = GM_DWELL;
                g_elapsed = '0;
                if (g_held) begin
                    g_held = 1'b0;
                    o.command = CMD_L_RELEASE;
                    o.release_left = 1'b1;
                end
            end
            KIND_MOTION: begin
                if (cfg_model.enabled) begin
                    moving = beyond_radius(int'($signed(r.step_x)), int'($signed(r.step_y)));
                    if (g_mode == GM_DIR) begin
                        if (moving) begin
                            if (!cfg_model.fast_gesture) g_elapsed = '0;
                        end else if (g_elapsed >= cfg_model.dwell_ticks) begin
                            gx = int'(r.pos_x) - int'(g_start_x);
                            gy = int'(r.pos_y) - int'(g_start_y);
                            if (beyond_radius(gx, gy)) begin
                                ax = (gx < 0) ? -gx : gx;
                                ay = (gy < 0) ? -gy : gy;
                                // vertical wins a tie
                                if (ax > ay)
                                    act = (gx < 0) ? cfg_model.action_left
                                                   : cfg_model.action_right;
                                else
                                    act = (gy < 0) ? cfg_model.action_top
                                                   : cfg_model.action_bottom;
                                o = fire_action(act);
                            end
                            g_mode = GM_WAIT;
                        end
                    end else if (g_mode == GM_WAIT) begin
                        if (moving) begin
                            g_elapsed = '0;
                            g_mode = GM_DWELL;
                        end
                    end else begin
                        if (moving) begin
                            g_elapsed = '0;
                        end else if (g_elapsed >= cfg_model.dwell_ticks) begin
                            g_elapsed = '0;
                            g_start_x = r.pos_x;
                            g_start_y = r.pos_y;
                            g_mode = GM_DIR;
                        end
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic flag_mismatch(string msg);
        n_errors++;
        $display("mismatch at result %0d: %s", n_checked, msg);
    endtask

    task automatic check_result(t_res got);
        t_res want;
        if (pending_cmds.size() == 0) begin
            flag_mismatch($sformatf("result with no request outstanding, command %0d",
                                    got.command));
            return;
        end
        want = pending_cmds.pop_front();
        if (got.command !== want.command)
            flag_mismatch($sformatf("command %0d, want %0d", got.command, want.command));
        if (got.release_left !== want.release_left)
            flag_mismatch($sformatf("release_left %0d, want %0d",
                                    got.release_left, want.release_left));
        if (got.move_pointer !== want.move_pointer)
            flag_mismatch($sformatf("move_pointer %0d, want %0d",
                                    got.move_pointer, want.move_pointer));
        if (got.move_x !== want.move_x)
            flag_mismatch($sformatf("move_x %0d, want %0d", got.move_x, want.move_x));
        if (got.move_y !== want.move_y)
            flag_mismatch($sformatf("move_y %0d, want %0d", got.move_y, want.move_y));
    endtask

    // monitor both channels at each edge
    always @(posedge i_clk) begin
        t_res pred;
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                n_checked++;
                check_result(t_res'{res_bus.command, res_bus.release_left,
                                    res_bus.move_pointer, res_bus.move_x, res_bus.move_y});
            end
            if (req_bus.valid && req_bus.ready) begin
                pred = predict_click(t_req'{req_bus.kind, req_bus.step_x, req_bus.step_y,
                                            req_bus.pos_x, req_bus.pos_y});
                if (offer_has_exp) pred = offer_exp;
                if (pred.move_pointer) n_returns++;
                pending_cmds.insert(pending_cmds.size(), pred);
            end
        end
    end

    // result receiver with random stalls and an occasional long hold-off
    initial begin
        int stall;
        forever begin
            if (long_hold > 0) begin
                stall = long_hold;
                long_hold = 0;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (res_bus.valid !== 1'b1);
        end
    end

    function automatic t_req make_req(logic [1:0] k, int sx, int sy, int px, int py);
        t_req r;
        r.kind = k;
        r.step_x = sx[11:0];
        r.step_y = sy[11:0];
        r.pos_x = px[COORD_BITS-1:0];
        r.pos_y = py[COORD_BITS-1:0];
        return r;
    endfunction

    function automatic t_row req_row(t_req r);
        t_row w;
        w.op = ROW_REQ;
        w.req = r;
        w.has_exp = 1'b0;
        w.exp = '0;
        w.reg_idx = '0;
        w.reg_val = '0;
        return w;
    endfunction

    function automatic t_row chk_row(t_req r, t_res e);
        t_row w;
        w = req_row(r);
        w.has_exp = 1'b1;
        w.exp = e;
        return w;
    endfunction

    function automatic t_row reg_row(logic [2:0] idx, logic [7:0] val);
        t_row w;
        w = req_row('0);
        w.op = ROW_REG;
        w.reg_idx = idx;
        w.reg_val = val;
        return w;
    endfunction

    function automatic int rand_coord();
        return $urandom_range(0, CMAX);
    endfunction

    function automatic int signed_rand(int mag);
        int v;
        v = $urandom_range(0, mag);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > CMAX) ? CMAX : v);
    endfunction

    // displacement within the stillness radius
    function automatic t_req still_req(int px, int py);
        int h;
        h = int'(cfg_model.tolerance) / 2;
        return make_req(KIND_MOTION, signed_rand(h), signed_rand(h), px, py);
    endfunction

    // displacement beyond the stillness radius on one axis
    function automatic t_req moving_req();
        int tol, mag, minor;
        tol = int'(cfg_model.tolerance);
        mag = tol + 1 + $urandom_range(0, 2046 - tol);
        minor = signed_rand(mag);
        if ($urandom_range(0, 1)) mag = -mag;
        if ($urandom_range(0, 1))
            return make_req(KIND_MOTION, mag, minor, rand_coord(), rand_coord());
        return make_req(KIND_MOTION, minor, mag, rand_coord(), rand_coord());
    endfunction

    // any kind, every field bit free
    function automatic t_req noise_req();
        return make_req(2'($urandom_range(0, 3)), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), rand_coord(), rand_coord());
    endfunction

    task automatic offer_request(t_req r, bit has_exp, t_res exp);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.kind   <= r.kind;
        req_bus.step_x <= r.step_x;
        req_bus.step_y <= r.step_y;
        req_bus.pos_x  <= r.pos_x;
        req_bus.pos_y  <= r.pos_y;
        offer_has_exp  <= has_exp;
        offer_exp      <= exp;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        n_sent++;
    endtask

    task automatic send_req(t_req r);
        offer_request(r, 1'b0, '0);
    endtask

    task automatic send_ticks(int n);
        repeat (n)
            send_req(make_req(KIND_TICK, $urandom_range(0, 4095), $urandom_range(0, 4095),
                              rand_coord(), rand_coord()));
    endtask

    // stop offering and let every outstanding result drain
    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            REG_ENABLED:       cfg_model.enabled = val[0];
            REG_DWELL_TICKS:   cfg_model.dwell_ticks = val;
            REG_TOLERANCE:     cfg_model.tolerance = val;
            REG_ACTION_LEFT:   cfg_model.action_left = val[2:0];
            REG_ACTION_RIGHT:  cfg_model.action_right = val[2:0];
            REG_ACTION_TOP:    cfg_model.action_top = val[2:0];
            REG_ACTION_BOTTOM: cfg_model.action_bottom = val[2:0];
            REG_FAST_GESTURE:  cfg_model.fast_gesture = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(t_cfg c);
        wait_idle();
        write_reg(REG_ENABLED, {7'd0, c.enabled});
        write_reg(REG_DWELL_TICKS, c.dwell_ticks);
        write_reg(REG_TOLERANCE, c.tolerance);
        write_reg(REG_ACTION_LEFT, {5'd0, c.action_left});
        write_reg(REG_ACTION_RIGHT, {5'd0, c.action_right});
        write_reg(REG_ACTION_TOP, {5'd0, c.action_top});
        write_reg(REG_ACTION_BOTTOM, {5'd0, c.action_bottom});
        write_reg(REG_FAST_GESTURE, {7'd0, c.fast_gesture});
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // leave wait, dwell, record a start, wander, dwell, then stop at a target
    task automatic run_gesture();
        int dw, sx, sy, gx, gy, m;
        dw = int'(cfg_model.dwell_ticks);
        send_req(moving_req());
        send_ticks(($urandom_range(0, 4) == 0) ? $urandom_range(0, dw)
                                               : dw + $urandom_range(0, 2));
        sx = rand_coord();
        sy = rand_coord();
        send_req(still_req(sx, sy));
        repeat ($urandom_range(0, 2)) send_req(moving_req());
        send_ticks(($urandom_range(0, 4) == 0) ? $urandom_range(0, dw)
                                               : dw + $urandom_range(0, 2));
        m = int'(cfg_model.tolerance) + 1 + $urandom_range(0, 400);
        case ($urandom_range(0, 9))
            0: begin
                gx = $urandom_range(0, 1) ? m : -m;
                gy = $urandom_range(0, 1) ? m : -m;
            end
            1, 2: begin
                gx = signed_rand(int'(cfg_model.tolerance) / 2);
                gy = signed_rand(int'(cfg_model.tolerance) / 2);
            end
            default: begin
                gx = signed_rand(m);
                gy = signed_rand(m);
                if ($urandom_range(0, 1)) gx = (gx < 0) ? -m : m;
                else gy = (gy < 0) ? -m : m;
            end
        endcase
        send_req(still_req(clamp_coord(sx + gx), clamp_coord(sy + gy)));
        repeat ($urandom_range(0, 2)) send_req(noise_req());
    endtask

    // stimulus
    initial begin
        t_row rows[$];
        t_cfg c;
        bit   cfg_open;
        int   phase_end;

        i_rst_n        <= 1'b0;
        req_bus.valid  <= 1'b0;
        req_bus.kind   <= KIND_MOTION;
        req_bus.step_x <= '0;
        req_bus.step_y <= '0;
        req_bus.pos_x  <= '0;
        req_bus.pos_y  <= '0;
        cfg_we         <= 1'b0;
        cfg_idx        <= REG_ENABLED;
        cfg_data       <= '0;
        offer_has_exp  = 1'b0;
        offer_exp      = '0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        long_hold      = 0;
        cfg_model = '{enabled: 1'b0, dwell_ticks: DWELL_TICKS_RST,
                      tolerance: TOLERANCE_RST, action_left: ACT_CLICK,
                      action_right: ACT_RIGHT, action_top: ACT_DOUBLE,
                      action_bottom: ACT_DRAG, fast_gesture: 1'b0};
        g_mode    = GM_DWELL;
        g_elapsed = '0;
        g_start_x = '0;
        g_start_y = '0;
        g_held    = 1'b0;

        // directed table: defaults first, then each gesture path with zero dwell
        rows = '{
            chk_row(make_req(KIND_MOTION, -2048, 2047, CMAX, 0), '0),
            chk_row(make_req(KIND_UNUSED, -1, -1, CMAX, CMAX), '0),
            chk_row(make_req(KIND_RESTART, 2047, -2048, 0, CMAX), '0),
            chk_row(make_req(KIND_TICK, 0, 0, 0, 0), '0),
            reg_row(REG_ENABLED, 8'd1),
            reg_row(REG_DWELL_TICKS, 8'd0),
            req_row(make_req(KIND_MOTION, 0, 0, 100, 100)),
            req_row(make_req(KIND_MOTION, 3, 0, 100, 90)),
            req_row(make_req(KIND_MOTION, 2, -3, 0, 0)),
            req_row(make_req(KIND_MOTION, 0, 0, 100, 100)),
            req_row(make_req(KIND_MOTION, 0, 0, 100, 150)),
            chk_row(make_req(KIND_RESTART, 0, 0, 0, 0),
                    t_res'{CMD_L_RELEASE, 1'b1, 1'b0, '0, '0}),
            req_row(make_req(KIND_MOTION, -1, 1, 200, 200)),
            req_row(make_req(KIND_MOTION, 0, 0, 200, 250)),
            req_row(make_req(KIND_MOTION, 2047, 2047, 0, 0)),
            req_row(make_req(KIND_MOTION, 0, 0, 200, 200)),
            req_row(make_req(KIND_MOTION, 0, 0, 150, 200)),
            req_row(make_req(KIND_MOTION, -2048, -2048, 0, 0)),
            req_row(make_req(KIND_MOTION, 0, 0, 0, 0)),
            req_row(make_req(KIND_MOTION, 0, 0, CMAX, 0)),
            req_row(make_req(KIND_MOTION, 5, 0, 0, 0)),
            req_row(make_req(KIND_MOTION, 0, 0, 500, 500)),
            req_row(make_req(KIND_MOTION, 0, 0, 510, 490)),
            req_row(make_req(KIND_MOTION, 0, -4, 0, 0)),
            req_row(make_req(KIND_MOTION, 0, 0, 1000, 1000)),
            req_row(make_req(KIND_MOTION, 0, 0, 1002, 1002)),
            req_row(make_req(KIND_TICK, -1, -1, CMAX, CMAX))
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cfg_open = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].op == ROW_REG) begin
                if (!cfg_open) begin
                    wait_idle();
                    cfg_open = 1'b1;
                end
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end else begin
                if (cfg_open) begin
                    cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                offer_request(rows[i].req, rows[i].has_exp, rows[i].exp);
            end
        end

        // random phases, each under its own register setting
        for (int p = 0; p < 8; p++) begin
            c.enabled       = 1'b1;
            c.dwell_ticks   = 8'($urandom_range(0, 6));
            c.tolerance     = 8'($urandom_range(0, 40));
            c.action_left   = 3'($urandom_range(0, 7));
            c.action_right  = 3'($urandom_range(0, 7));
            c.action_top    = 3'($urandom_range(0, 7));
            c.action_bottom = 3'($urandom_range(0, 7));
            c.fast_gesture  = 1'($urandom_range(0, 1));
            case (p)
                0: begin
                    c.dwell_ticks = 8'd0;
                    c.tolerance = 8'd0;
                end
                1: begin
                    c.dwell_ticks = 8'hFF;
                    c.tolerance = 8'hFF;
                end
                2: begin
                    // zero dwell records the start point without waiting for ticks
                    c.dwell_ticks = 8'd0;
                    c.action_left = ACT_DRAG;
                    c.action_right = ACT_NONE;
                    c.action_top = ACT_RSVD6;
                    c.action_bottom = ACT_RSVD7;
                end
                3: c.enabled = 1'b0;
                7: begin
                    c.dwell_ticks = DWELL_TICKS_RST;
                    c.tolerance = TOLERANCE_RST;
                end
                default: ;
            endcase
            apply_settings(c);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (p == 4 || p == 6) begin
                // sender keeps offering while the receiver holds off
                tx_idle_on = 1'b0;
                long_hold = LONG_HOLD;
            end
            if (p == 1) begin
                // countdown must saturate, not wrap, before the start is recorded
                send_req(moving_req());
                send_ticks(256 + $urandom_range(0, 6));
                send_req(still_req(rand_coord(), rand_coord()));
            end else begin
                phase_end = n_sent + ((p == 3) ? 30 : 80);
                while (n_sent < phase_end) begin
                    run_gesture();
                    if ($urandom_range(0, 7) == 0) wait_idle();
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests under %0d register settings, %0d results checked",
                 n_sent, n_settings, n_checked);
        $display("%0d results returned the pointer to a gesture start", n_returns);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
